// File: rtl/bfsc_pkg.sv
// Shared types and constants of the button fan speed controller.
`default_nettype none
package bfsc_pkg;

	// Event kinds carried on the input tuser
	typedef enum logic [1:0] {
		OP_POWER_ON = 2'd0,
		OP_PLUS     = 2'd1,
		OP_MINUS    = 2'd2,
		OP_BOTH     = 2'd3
	} op_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_RATE_STEP = 2'd0;
	localparam logic [1:0] CFG_MAX_RATE  = 2'd1;
	localparam logic [1:0] CFG_STROBE    = 2'd2;
	localparam logic [1:0] CFG_POWER_OFF = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int STEP_W     = 16;
	localparam int HOLD_W     = 16;
	localparam int SPEED_W    = 7;

	localparam logic [STEP_W-1:0]  RATE_STEP_RST = 16'd500;
	localparam logic [SPEED_W-1:0] MAX_RATE_RST  = 7'd10;
	localparam logic [HOLD_W-1:0]  STROBE_RST    = 16'd2000;
	localparam logic [HOLD_W-1:0]  POWER_OFF_RST = 16'd5000;

	// Mode codes
	localparam logic [1:0] MODE_OFF    = 2'd0;
	localparam logic [1:0] MODE_MANUAL = 2'd1;
	localparam logic [1:0] MODE_DOWN   = 2'd2;

	// Indicator colour codes
	localparam logic [2:0] IND_NONE    = 3'd0;
	localparam logic [2:0] IND_GREEN   = 3'd1;
	localparam logic [2:0] IND_MAGENTA = 3'd2;
	localparam logic [2:0] IND_YELLOW  = 3'd3;
	localparam logic [2:0] IND_CYAN    = 3'd4;
	localparam logic [2:0] IND_BLINK   = 3'd5;

	typedef struct packed {
		logic [STEP_W-1:0]  rate_step;
		logic [SPEED_W-1:0] max_rate;
		logic [HOLD_W-1:0]  strobe_hold;
		logic [HOLD_W-1:0]  power_off_hold;
	} cfg_t;

	// Classified event: kind plus both-button hold decisions
	typedef struct packed {
		logic pwr_hit;
		logic strb_hit;
		op_t  op;
	} cls_t;

	// Result item, first member in the top bits so mode lands in bits 1:0
	typedef struct packed {
		logic               event_taken;
		logic [2:0]         indicator_code;
		logic               strobe_toggled;
		logic               strobe_on;
		logic               fan_update;
		logic [SPEED_W-1:0] fan_speed;
		logic [1:0]         mode;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/bfsc_queue.sv
// Two-entry queue between the front and back parts.
`default_nettype none
module bfsc_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              full,
	output logic              empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/bfsc_front.sv
// Front part: takes input transactions, decodes the kind and judges both-button holds.
`default_nettype none
module bfsc_front import bfsc_pkg::*; #(
	parameter int DURATION_BITS = 16
) (
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [2*DURATION_BITS+1:0] s_fields,
	input  wire logic [1:0]               s_tuser,
	input  wire cfg_t                     cfg,
	input  wire logic                     q_full,
	output logic                          q_push,
	output cls_t                          q_cls,
	output logic [DURATION_BITS-1:0]      q_dur
);

	localparam int CW = (DURATION_BITS > HOLD_W) ? DURATION_BITS : HOLD_W;

	logic [DURATION_BITS-1:0] plus_dur;
	logic [DURATION_BITS-1:0] minus_dur;
	logic                     plus_long;
	logic                     minus_long;
	logic                     both_long;
	logic [CW-1:0]            pd_x;
	logic [CW-1:0]            md_x;
	logic [CW-1:0]            off_x;
	logic [CW-1:0]            strb_x;

	assign plus_dur   = s_fields[DURATION_BITS-1:0];
	assign plus_long  = s_fields[DURATION_BITS];
	assign minus_dur  = s_fields[2*DURATION_BITS:DURATION_BITS+1];
	assign minus_long = s_fields[2*DURATION_BITS+1];

	assign pd_x   = CW'(plus_dur);
	assign md_x   = CW'(minus_dur);
	assign off_x  = CW'(cfg.power_off_hold);
	assign strb_x = CW'(cfg.strobe_hold);

	assign both_long = plus_long && minus_long;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;
	assign q_dur    = plus_dur;

	always_comb begin
		q_cls.op       = op_t'(s_tuser);
		q_cls.pwr_hit  = both_long && (pd_x >= off_x) && (md_x >= off_x);
		q_cls.strb_hit = both_long && (pd_x >= strb_x) && (md_x >= strb_x);
	end

endmodule
`default_nettype wire

// File: rtl/bfsc_back.sv
// Back part: serial rate divider, mode/speed/strobe state and the output register.
`default_nettype none
module bfsc_back import bfsc_pkg::*; #(
	parameter int DURATION_BITS = 16,
	parameter int SPEED_MAX     = 100
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cfg_t                     cfg,
	input  wire logic                     q_empty,
	input  wire cls_t                     q_cls,
	input  wire logic [DURATION_BITS-1:0] q_dur,
	output logic                          q_pop,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output res_t                          m_res
);

	localparam int CNT_W = $clog2(DURATION_BITS);
	localparam logic [SPEED_W-1:0] SPD_MAX = SPEED_W'(SPEED_MAX);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_RES  = 3'b100
	} st_t;

	st_t                      st_q;
	cls_t                     cls_q;
	logic [DURATION_BITS-1:0] dvd_q;
	logic [STEP_W-1:0]        rem_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [1:0]               mode_q;
	logic [SPEED_W-1:0]       speed_q;
	logic                     strobe_q;
	logic                     m_tvalid_q;
	res_t                     res_q;

	logic                     out_free;
	logic                     commit;
	logic [STEP_W:0]          rem_nx;
	logic                     rem_sub;
	logic                     step_zero;
	logic                     q_ge;
	logic [SPEED_W-1:0]       rate;
	logic [SPEED_W:0]         sum;
	logic                     live;
	logic [1:0]               mode_d;
	logic [SPEED_W-1:0]       speed_d;
	logic                     strobe_d;
	res_t                     res_d;

	assign out_free = !m_tvalid_q || m_tready;
	assign commit   = (st_q == ST_RES) && out_free;
	assign q_pop    = (st_q == ST_IDLE) && !q_empty;
	assign m_tvalid = m_tvalid_q;
	assign m_res    = res_q;

	// restoring division, one quotient bit a cycle
	assign rem_nx  = {rem_q, dvd_q[DURATION_BITS-1]};
	assign rem_sub = (rem_nx >= {1'b0, cfg.rate_step});

	assign step_zero = (cfg.rate_step == '0);
	assign q_ge      = (dvd_q >= DURATION_BITS'(cfg.max_rate));
	assign rate      = (step_zero || q_ge) ? cfg.max_rate : dvd_q[SPEED_W-1:0] + 7'd1;
	assign sum       = {1'b0, speed_q} + {1'b0, rate};
	assign live      = (mode_q == MODE_OFF) || (mode_q == MODE_MANUAL);

	always_comb begin
		mode_d   = mode_q;
		speed_d  = speed_q;
		strobe_d = strobe_q;
		res_d    = '0;
		case (cls_q.op)
			OP_POWER_ON: begin
				if (mode_q == MODE_OFF) begin
					mode_d               = MODE_MANUAL;
					res_d.fan_update     = 1'b1;
					res_d.indicator_code = IND_BLINK;
					res_d.event_taken    = 1'b1;
				end
			end
			OP_PLUS: begin
				if (mode_q == MODE_MANUAL) begin
					if (sum < {1'b0, SPD_MAX}) begin
						speed_d              = sum[SPEED_W-1:0];
						res_d.indicator_code = IND_GREEN;
					end else begin
						speed_d              = SPD_MAX;
						res_d.indicator_code = IND_MAGENTA;
					end
					res_d.fan_update  = 1'b1;
					res_d.event_taken = 1'b1;
				end
			end
			OP_MINUS: begin
				if (mode_q == MODE_MANUAL) begin
					if (speed_q > 7'd1) begin
						speed_d              = speed_q - 7'd1;
						res_d.indicator_code = IND_YELLOW;
					end else begin
						speed_d              = '0;
						res_d.indicator_code = IND_MAGENTA;
					end
					res_d.fan_update  = 1'b1;
					res_d.event_taken = 1'b1;
				end
			end
			OP_BOTH: begin
				if (live && cls_q.pwr_hit) begin
					mode_d               = MODE_DOWN;
					strobe_d             = 1'b0;
					speed_d              = '0;
					res_d.fan_update     = 1'b1;
					res_d.indicator_code = IND_CYAN;
					res_d.event_taken    = 1'b1;
				end else if (live && cls_q.strb_hit) begin
					strobe_d             = ~strobe_q;
					res_d.strobe_toggled = 1'b1;
					res_d.event_taken    = 1'b1;
				end
			end
			default: ;
		endcase
		res_d.mode      = mode_d;
		res_d.fan_speed = speed_d;
		res_d.strobe_on = strobe_d;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cls_q <= q_cls;
			dvd_q <= q_dur;
			rem_q <= '0;
			cnt_q <= CNT_W'(DURATION_BITS - 1);
		end else if (st_q == ST_DIV) begin
			rem_q <= rem_sub ? STEP_W'(rem_nx - {1'b0, cfg.rate_step}) : STEP_W'(rem_nx);
			dvd_q <= {dvd_q[DURATION_BITS-2:0], rem_sub};
			cnt_q <= cnt_q - 1'b1;
		end
		if (commit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			mode_q     <= MODE_OFF;
			speed_q    <= '0;
			strobe_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_cls.op == OP_PLUS && mode_q == MODE_MANUAL && !step_zero) begin
							st_q <= ST_DIV;
						end else begin
							st_q <= ST_RES;
						end
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						st_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (commit) begin
				mode_q     <= mode_d;
				speed_q    <= speed_d;
				strobe_q   <= strobe_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/button_fan_speed_controller.sv
// Top level of the button fan speed controller.
//
// Usage notes:
//  - Input stream (s_*): one button event per transaction. s_tuser carries the
//    event kind, s_tdata the press durations and long-press flags.
//  - Output stream (m_*): exactly one result transaction per input event, in
//    order: mode, fan speed, strobe state, action flags and indicator colour.
//  - Config port: cfg_we with cfg_index/cfg_wdata writes one register per edge.
//    Write only while no event is in flight.
//  - Front part classifies the event (kind, both-button hold thresholds) and
//    drops it into a two-entry queue; the back part pops it and executes it.
//  - Path from input acceptance to m_tvalid: the queue entry, the back part's
//    result state and the output register; a plus press in manual mode with a
//    nonzero rate step also passes the rate divider, one quotient bit per cycle.
//  - The back part pops the next event only once the previous result has entered
//    the output register; meanwhile the queue accepts up to two further events.
//  - Reset: mode off, speed 0, strobe off, registers at their defaults,
//    queue and output register empty.
//  - Receiver stall: the result is held in the output register; the back part
//    waits, the queue fills, and s_tready drops once both entries are taken.
`default_nettype none
module button_fan_speed_controller import bfsc_pkg::*; #(
	parameter int DURATION_BITS = 16,
	parameter int SPEED_MAX     = 100
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// s_tdata, from bit 0: plus_duration, plus_long, minus_duration, minus_long, zero pad
	input  wire logic [((2*DURATION_BITS+2+7)/8)*8-1:0] s_tdata,
	// s_tuser: operation
	input  wire logic [1:0]             s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// m_tdata, from bit 0: mode, fan_speed, fan_update, strobe_on, strobe_toggled,
	// indicator_code, event_taken
	output logic [$bits(res_t)-1:0]     m_tdata,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int FW = 2 * DURATION_BITS + 2;
	localparam int QW = DURATION_BITS + $bits(cls_t);

	cfg_t                     cfg_q;
	logic                     q_full;
	logic                     q_empty;
	logic                     q_push;
	logic                     q_pop;
	cls_t                     f_cls;
	logic [DURATION_BITS-1:0] f_dur;
	logic [QW-1:0]            q_rdata;
	res_t                     res;

	// configuration bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_step      <= RATE_STEP_RST;
			cfg_q.max_rate       <= MAX_RATE_RST;
			cfg_q.strobe_hold    <= STROBE_RST;
			cfg_q.power_off_hold <= POWER_OFF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RATE_STEP: cfg_q.rate_step      <= cfg_wdata[STEP_W-1:0];
				CFG_MAX_RATE:  cfg_q.max_rate       <= cfg_wdata[SPEED_W-1:0];
				CFG_STROBE:    cfg_q.strobe_hold    <= cfg_wdata[HOLD_W-1:0];
				CFG_POWER_OFF: cfg_q.power_off_hold <= cfg_wdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	bfsc_front #(
		.DURATION_BITS(DURATION_BITS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_fields (s_tdata[FW-1:0]),
		.s_tuser  (s_tuser),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cls    (f_cls),
		.q_dur    (f_dur)
	);

	bfsc_queue #(
		.W(QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({f_dur, f_cls}),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	bfsc_back #(
		.DURATION_BITS(DURATION_BITS),
		.SPEED_MAX    (SPEED_MAX)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_cls    (cls_t'(q_rdata[$bits(cls_t)-1:0])),
		.q_dur    (q_rdata[QW-1:$bits(cls_t)]),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_res    (res)
	);

	assign m_tdata = res;

endmodule
`default_nettype wire

// File: rtl/bfsc_checker.sv
// Port-level checks of the button fan speed controller and their bind.
`default_nettype none
module bfsc_checker import bfsc_pkg::*; #(
	parameter int SPEED_MAX = 100
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    m_tvalid,
	input wire logic                    m_tready,
	input wire logic [$bits(res_t)-1:0] m_tdata
);

	res_t r;
	logic down_seen_q;

	assign r = m_tdata;

	// remembers that a powered-down result has gone out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_seen_q <= 1'b0;
		end else if (m_tvalid && m_tready && r.mode == MODE_DOWN) begin
			down_seen_q <= 1'b1;
		end
	end

	a_down_terminal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && down_seen_q |-> r.mode == MODE_DOWN)
		else $error("result left powered-down mode");

	a_speed_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> r.fan_speed <= SPEED_W'(SPEED_MAX))
		else $error("fan speed above limit");

	a_ignored_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !r.event_taken |->
			!r.fan_update && !r.strobe_toggled && r.indicator_code == IND_NONE)
		else $error("ignored event shows an action");

	a_toggle_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.strobe_toggled |-> r.indicator_code == IND_NONE && r.mode != MODE_DOWN)
		else $error("strobe toggle with wrong indicator or mode");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

endmodule

bind button_fan_speed_controller bfsc_checker #(
	.SPEED_MAX(SPEED_MAX)
) u_bfsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench of the button fan speed controller.
`timescale 1ns / 100ps
module tb_top;
	import bfsc_pkg::*;

	localparam int DUR_W       = 16;
	localparam int SPEED_TOP   = 100;
	localparam int TDATA_W     = ((2*DUR_W+2+7)/8)*8;
	localparam int CYCLE_LIMIT = 800000;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_WAIT  = 40;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [TDATA_W-1:0]    s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [$bits(res_t)-1:0] m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// Local copy of the controller state and its registers
	logic [1:0]         st_mode;
	logic [SPEED_W-1:0] st_speed;
	logic               st_strobe;
	logic [STEP_W-1:0]  reg_step;
	logic [SPEED_W-1:0] reg_max_rate;
	logic [HOLD_W-1:0]  reg_strobe_hold;
	logic [HOLD_W-1:0]  reg_power_off;

	res_t status_due[$];
	res_t want;
	res_t got;
	int   errors = 0;
	int   cycles = 0;
	bit   idle_on = 1'b0;
	int   hold_reqs = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   stall_left = 0;

	button_fan_speed_controller #(
		.DURATION_BITS(DUR_W),
		.SPEED_MAX    (SPEED_TOP)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(20, 60);
	endfunction

	// Status after one button event; updates the local state
	function automatic res_t next_status(op_t op, logic [15:0] pd, logic pl,
			logic [15:0] md, logic ml);
		res_t        r;
		int unsigned rate;
		int unsigned sum;
		r = '0;
		if (st_mode == MODE_OFF || st_mode == MODE_MANUAL) begin
			case (op)
				OP_POWER_ON: begin
					if (st_mode == MODE_OFF) begin
						st_mode = MODE_MANUAL;
						r.fan_update = 1'b1;
						r.indicator_code = IND_BLINK;
						r.event_taken = 1'b1;
					end
				end
				OP_PLUS: begin
					if (st_mode == MODE_MANUAL) begin
						// zero step saturates the quotient, so the rate is max_rate
						if (reg_step == '0)
							rate = 32'(reg_max_rate);
						else
							rate = int'(pd) / int'(reg_step) + 1;
						if (rate > reg_max_rate)
							rate = 32'(reg_max_rate);
						sum = st_speed + rate;
						if (sum < SPEED_TOP) begin
							st_speed = sum[SPEED_W-1:0];
							r.indicator_code = IND_GREEN;
						end else begin
							st_speed = SPEED_W'(SPEED_TOP);
							r.indicator_code = IND_MAGENTA;
						end
						r.fan_update = 1'b1;
						r.event_taken = 1'b1;
					end
				end
				OP_MINUS: begin
					if (st_mode == MODE_MANUAL) begin
						if (st_speed > 1) begin
							st_speed = st_speed - 1'b1;
							r.indicator_code = IND_YELLOW;
						end else begin
							st_speed = '0;
							r.indicator_code = IND_MAGENTA;
						end
						r.fan_update = 1'b1;
						r.event_taken = 1'b1;
					end
				end
				default: begin
					// power-off hold wins over the strobe hold
					if (pl && ml && pd >= reg_power_off && md >= reg_power_off) begin
						st_mode = MODE_DOWN;
						st_strobe = 1'b0;
						st_speed = '0;
						r.fan_update = 1'b1;
						r.indicator_code = IND_CYAN;
						r.event_taken = 1'b1;
					end else if (pl && ml && pd >= reg_strobe_hold &&
							md >= reg_strobe_hold) begin
						st_strobe = ~st_strobe;
						r.strobe_toggled = 1'b1;
						r.event_taken = 1'b1;
					end
				end
			endcase
		end
		r.mode = st_mode;
		r.fan_speed = st_speed;
		r.strobe_on = st_strobe;
		return r;
	endfunction

	// One button event transaction; the status is predicted at acceptance
	task automatic press(input op_t op, input logic [15:0] pd, input logic pl,
			input logic [15:0] md, input logic ml);
		int gap;
		gap = (idle_on && $urandom_range(0, 1)) ? pick_len() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser = op;
		s_tdata = TDATA_W'({ml, md, pl, pd});
		s_tvalid = 1'b1;
		do begin
			@(posedge clk);
		end while (!s_tready);
		status_due.push_back(next_status(op, pd, pl, md, ml));
	endtask

	// Drop valid and wait for every outstanding status
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_RATE_STEP: reg_step = val;
			CFG_MAX_RATE:  reg_max_rate = val[SPEED_W-1:0];
			CFG_STROBE:    reg_strobe_hold = val;
			default:       reg_power_off = val;
		endcase
	endtask

	// Duration spread: full range, short, around a threshold, or an extreme
	function automatic logic [15:0] pick_dur(int th);
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(0, 65535);
			1: v = $urandom_range(0, 3000);
			2: v = th + $urandom_range(0, 2) - 1;
			default: v = $urandom_range(0, 1) ? 65535 : 0;
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	// Random event; unless allowed, a both-button power-off is steered just below the hold
	task automatic rand_event(input bit allow_down);
		op_t         op;
		logic [15:0] pd;
		logic [15:0] md;
		logic        pl;
		logic        ml;
		int          r;
		int          th;
		r = $urandom_range(0, 99);
		if (r < 5)
			op = OP_POWER_ON;
		else if (r < ((st_speed > 60) ? 30 : 45))
			op = OP_PLUS;
		else if (r < 80)
			op = OP_MINUS;
		else
			op = OP_BOTH;
		if (op == OP_PLUS)
			th = int'(reg_step) * $urandom_range(0, 12);
		else
			th = $urandom_range(0, 1) ? int'(reg_strobe_hold) : int'(reg_power_off);
		pd = pick_dur(th);
		md = pick_dur(th);
		pl = ($urandom_range(0, 3) != 0);
		ml = ($urandom_range(0, 3) != 0);
		if (!allow_down && op == OP_BOTH && pl && ml && pd >= reg_power_off &&
				md >= reg_power_off)
			md = reg_power_off - 1'b1;
		press(op, pd, pl, md, ml);
	endtask

	// Sink side: long hold-off on request, random stalls while idling is on
	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready = 1'b0;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			stall_left = pick_len() - 1;
			m_tready = 1'b0;
		end else begin
			m_tready = 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	// Status transactions against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (status_due.size() == 0) begin
				$error("status transaction with no event outstanding: %h", m_tdata);
				errors++;
			end else begin
				want = status_due.pop_front();
				got = res_t'(m_tdata);
				check_field("mode", 16'(want.mode), 16'(got.mode));
				check_field("fan_speed", 16'(want.fan_speed), 16'(got.fan_speed));
				check_field("fan_update", 16'(want.fan_update), 16'(got.fan_update));
				check_field("strobe_on", 16'(want.strobe_on), 16'(got.strobe_on));
				check_field("strobe_toggled", 16'(want.strobe_toggled),
					16'(got.strobe_toggled));
				check_field("indicator_code", 16'(want.indicator_code),
					16'(got.indicator_code));
				check_field("event_taken", 16'(want.event_taken), 16'(got.event_taken));
			end
		end
	end

	// Events before power-on, then the power-on itself and a second, ignored one
	task automatic test_off_mode();
		press(OP_PLUS, 16'hFFFF, 1'b1, 16'd0, 1'b0);
		press(OP_MINUS, 16'd0, 1'b0, 16'd0, 1'b0);
		press(OP_BOTH, 16'd2000, 1'b1, 16'd2000, 1'b1);     // exactly at strobe hold
		press(OP_BOTH, 16'd1999, 1'b1, 16'hFFFF, 1'b1);     // one button just short
		press(OP_BOTH, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0);     // minus not long
		press(OP_POWER_ON, 16'd0, 1'b0, 16'd0, 1'b0);
		press(OP_POWER_ON, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1); // already on: ignored
	endtask

	// Speed saturation at both ends and rate steps, default registers
	task automatic test_manual_speed();
		press(OP_MINUS, 16'd0, 1'b0, 16'd0, 1'b0);          // floor
		press(OP_PLUS, 16'd0, 1'b0, 16'd0, 1'b0);
		press(OP_MINUS, 16'd0, 1'b0, 16'hFFFF, 1'b1);        // from one down to floor
		press(OP_PLUS, 16'd499, 1'b0, 16'd0, 1'b0);
		press(OP_PLUS, 16'd500, 1'b1, 16'd0, 1'b0);
		repeat (10)
			press(OP_PLUS, 16'hFFFF, 1'b1, 16'd0, 1'b0);     // rate capped, then ceiling
		press(OP_MINUS, 16'd0, 1'b0, 16'd0, 1'b0);
		press(OP_BOTH, 16'd4999, 1'b1, 16'd4999, 1'b1);     // just short of power-off
		press(OP_BOTH, 16'hFFFF, 1'b1, 16'd4999, 1'b1);
	endtask

	task automatic load_regs(input logic [15:0] step, input logic [15:0] max_r,
			input logic [15:0] strobe_h, input logic [15:0] power_h, input int n);
		settle();
		write_reg(CFG_RATE_STEP, step);
		write_reg(CFG_MAX_RATE, max_r);
		write_reg(CFG_STROBE, strobe_h);
		write_reg(CFG_POWER_OFF, power_h);
		idle_on = ~idle_on;
		repeat (n)
			rand_event(1'b0);
	endtask

	// Random events in manual mode across register settings, extremes included
	task automatic test_register_sweep();
		load_regs(16'd1, 16'd100, 16'd0, 16'hFFFF, 210);
		load_regs(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 210);
		load_regs(16'd0, 16'd127, 16'd1000, 16'hFFFF, 210);
		load_regs(16'd300, 16'd0, 16'd40000, 16'd20000, 210);
		load_regs(16'd500, 16'd10, 16'd2000, 16'd5000, 210);
		load_regs(16'($urandom_range(1, 4000)), 16'($urandom_range(0, 127)),
			16'($urandom_range(0, 30000)), 16'($urandom_range(30000, 65535)), 210);
	endtask

	// Sink holds off while the source keeps offering back to back
	task automatic test_backpressure();
		settle();
		idle_on = 1'b0;
		@(posedge clk);
		hold_reqs++;
		repeat (16)
			rand_event(1'b0);
	endtask

	// Power-off with a zero hold, then everything is ignored
	task automatic test_power_down();
		settle();
		write_reg(CFG_POWER_OFF, 16'd0);
		idle_on = 1'b1;
		press(OP_BOTH, 16'd0, 1'b1, 16'd0, 1'b1);
		repeat (40)
			rand_event(1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		st_mode = MODE_OFF;
		st_speed = '0;
		st_strobe = 1'b0;
		reg_step = RATE_STEP_RST;
		reg_max_rate = MAX_RATE_RST;
		reg_strobe_hold = STROBE_RST;
		reg_power_off = POWER_OFF_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_off_mode();
		test_manual_speed();
		test_register_sweep();
		test_backpressure();
		test_power_down();

		@(negedge clk);
		s_tvalid = 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/bfsc_pkg.sv
rtl/bfsc_queue.sv
rtl/bfsc_front.sv
rtl/bfsc_back.sv
rtl/button_fan_speed_controller.sv
rtl/bfsc_checker.sv
dv/tb_top.sv
